>>> rtl/core/lru_page_replacement_macros.svh
// ----------------------------------------------------------------------------
// LRU page replacement - assertion macros
// Immediate-style wrappers around concurrent assertions; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LRU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru_page_replacement: assertion failed");
// next-cycle implication
`define LRU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru_page_replacement: assertion failed");
`else
`define LRU_ASSERT_IMP(label, clk, rst, ante, cons)
`define LRU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/lru_pr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement - shared package
// Sizes, state and command encodings, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int RANK_W     = FRAME_W;
  localparam int COUNT_W    = FRAME_W + 1;
  localparam int PAGE_W     = 8;
  localparam int CFG_W      = 5;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_FILL,
    ST_REPLACE
  } state_t;

  typedef enum logic [1:0] {
    KIND_HIT,
    KIND_FILL,
    KIND_REPLACE
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic  start;   // latch request, restart scan
    logic  scan;    // frame at scan index is examined this cycle
    logic  step;    // advance scan index
    logic  update;  // apply frame update and load result
    kind_t kind;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_valid;
    logic page_match;
    logic last_frame;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/core/lru_pr_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page replacement - controller
// Sequences accept, frame scan and the final hit/fill/replace update.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lru_pr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  lru_pr_pkg::stat_t stat,
  output lru_pr_pkg::cmd_t  cmd
);

  lru_pr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lru_pr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = lru_pr_pkg::KIND_HIT;
    s_tready   = 1'b0;
    unique case (state)
      lru_pr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = lru_pr_pkg::ST_SCAN;
        end
      end
      lru_pr_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!stat.slot_valid) begin
          state_next = lru_pr_pkg::ST_FILL;
        end else if (stat.page_match) begin
          state_next = lru_pr_pkg::ST_HIT;
        end else if (stat.last_frame) begin
          state_next = lru_pr_pkg::ST_REPLACE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      lru_pr_pkg::ST_HIT: begin
        cmd.kind = lru_pr_pkg::KIND_HIT;
        if (!stat.out_busy) begin
          cmd.update = 1'b1;
          state_next = lru_pr_pkg::ST_IDLE;
        end
      end
      lru_pr_pkg::ST_FILL: begin
        cmd.kind = lru_pr_pkg::KIND_FILL;
        if (!stat.out_busy) begin
          cmd.update = 1'b1;
          state_next = lru_pr_pkg::ST_IDLE;
        end
      end
      lru_pr_pkg::ST_REPLACE: begin
        cmd.kind = lru_pr_pkg::KIND_REPLACE;
        if (!stat.out_busy) begin
          cmd.update = 1'b1;
          state_next = lru_pr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lru_pr_pkg::ST_IDLE;
      end
    endcase
  end

  `LRU_ASSERT_NXT(a_accept_scan, clk, rst, s_tvalid && s_tready, state == lru_pr_pkg::ST_SCAN)
  `LRU_ASSERT_NXT(a_update_idle, clk, rst, cmd.update, state == lru_pr_pkg::ST_IDLE)
  `LRU_ASSERT_IMP(a_no_overrun, clk, rst, cmd.update, !stat.out_busy)

endmodule

>>> rtl/core/lru_pr_datapath.sv
// ----------------------------------------------------------------------------
// LRU page replacement - datapath
// Frame tables, scan index, victim tracking, rank update and result register.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lru_pr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lru_pr_pkg::cmd_t                    cmd,
  output lru_pr_pkg::stat_t                   stat,
  input  logic                                cfg_we,
  input  logic [lru_pr_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [lru_pr_pkg::PAGE_W-1:0]       s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lru_pr_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [1:0]                          m_tuser
);

  localparam int FW = lru_pr_pkg::FRAME_W;
  localparam int RW = lru_pr_pkg::RANK_W;
  localparam int PW = lru_pr_pkg::PAGE_W;
  localparam int CW = lru_pr_pkg::COUNT_W;
  localparam int NF = lru_pr_pkg::MAX_FRAMES;
  localparam int PAD_W = lru_pr_pkg::OUT_DATA_W - FW - PW;

  logic [lru_pr_pkg::CFG_W-1:0] frame_count;
  logic [NF-1:0]                valid;
  logic [CW-1:0]                vcount;
  logic [PW-1:0]                page_arr [NF];
  logic [RW-1:0]                rank_arr [NF];
  logic [PW-1:0]                req_page;
  logic [FW-1:0]                idx;
  logic [FW-1:0]                victim;
  logic [RW-1:0]                min_rank;

  logic          out_fault;
  logic          out_replaced;
  logic [FW-1:0] out_frame;
  logic [PW-1:0] out_rpage;

  logic [FW-1:0] last_idx;
  logic [FW-1:0] sel;
  logic [PW-1:0] sel_page;
  logic [RW-1:0] sel_rank;
  logic [RW-1:0] top_rank;
  logic          is_replace;

  // clamp frame count to 1..NF, expressed as last index
  always_comb begin
    if (frame_count == '0) begin
      last_idx = '0;
    end else if (frame_count > lru_pr_pkg::CFG_W'(NF)) begin
      last_idx = FW'(NF - 1);
    end else begin
      last_idx = FW'(frame_count - 1'b1);
    end
  end

  assign is_replace = cmd.update && (cmd.kind == lru_pr_pkg::KIND_REPLACE);
  assign sel        = is_replace ? victim : idx;
  assign sel_page   = page_arr[sel];
  assign sel_rank   = rank_arr[sel];
  assign top_rank   = RW'(vcount - 1'b1);

  assign stat.slot_valid = valid[sel];
  assign stat.page_match = (sel_page == req_page);
  assign stat.last_frame = (idx == last_idx);
  assign stat.out_busy   = m_tvalid && !m_tready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= lru_pr_pkg::FRAME_COUNT_RESET;
      valid       <= '0;
      vcount      <= '0;
      idx         <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_count <= cfg_wdata;
      end
      if (cmd.start) begin
        idx <= '0;
        if (s_tuser) begin
          valid  <= '0;
          vcount <= '0;
        end
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.update && (cmd.kind == lru_pr_pkg::KIND_FILL)) begin
        valid[sel] <= 1'b1;
        vcount     <= vcount + 1'b1;
      end
      if (cmd.update) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // frame tables and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_page <= s_tdata;
    end
    if (cmd.scan) begin
      if ((idx == '0) || (sel_rank < min_rank)) begin
        min_rank <= sel_rank;
        victim   <= idx;
      end
    end
    if (cmd.update) begin
      if (cmd.kind == lru_pr_pkg::KIND_FILL) begin
        rank_arr[sel] <= RW'(vcount);
      end else begin
        // touch: ranks above the touched one slide down, touched goes to top
        for (int i = 0; i < NF; i++) begin
          if (FW'(i) == sel) begin
            rank_arr[i] <= top_rank;
          end else if (valid[i] && (rank_arr[i] > sel_rank)) begin
            rank_arr[i] <= rank_arr[i] - 1'b1;
          end
        end
      end
      if (cmd.kind != lru_pr_pkg::KIND_HIT) begin
        page_arr[sel] <= req_page;
      end
      out_fault    <= (cmd.kind != lru_pr_pkg::KIND_HIT);
      out_replaced <= is_replace;
      out_frame    <= sel;
      out_rpage    <= is_replace ? sel_page : '0;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_rpage, out_frame};
  assign m_tuser = {out_replaced, out_fault};

  `LRU_ASSERT_IMP(a_victim_valid, clk, rst, is_replace, valid[victim])
  `LRU_ASSERT_IMP(a_count_range, clk, rst, 1'b1, vcount <= CW'(NF))
  `LRU_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

>>> rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement - top level
// Page reference stream in, one fault/frame/eviction result per reference out.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Accept            Payload
// s_*       in   tvalid & tready   tdata: page; tuser: new_sequence
// m_*       out  tvalid & tready   tdata: frame_index, replaced_page; tuser: fault, replaced
// cfg_*     in   cfg_we            cfg_wdata: frame_count
//
// A request is accepted in ST_IDLE, then frames are scanned in index order, one
// frame per cycle, up to the first empty or matching frame or the last frame;
// an update state then loads the result into the output register.
// The next request is taken once the result is in the output register, even if
// the sink has not yet taken it; the update waits while that register is full.
// Reset (rst, synchronous) empties all frames and sets frame_count to 4.
// new_sequence empties all frames at accept, before the scan.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic                              clk,
  input  logic                              rst,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lru_pr_pkg::PAGE_W-1:0]     s_tdata,   // [7:0] page
  input  logic                              s_tuser,   // [0] new_sequence
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lru_pr_pkg::OUT_DATA_W-1:0] m_tdata,   // [3:0] frame_index, [11:4] replaced_page
  output logic [1:0]                        m_tuser,   // [0] fault, [1] replaced
  // frame count register
  input  logic                              cfg_we,
  input  logic [lru_pr_pkg::CFG_W-1:0]      cfg_wdata
);

  // controller drives scan/update commands, datapath reports frame status
  lru_pr_pkg::cmd_t  cmd;
  lru_pr_pkg::stat_t stat;

  lru_pr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lru_pr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

>>> bench/tb_lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement - testbench
// Streams page references into the block and checks every fault / frame /
// eviction result against a cycle-free LRU predictor. A short directed run
// comes first, then random phases over several frame counts and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lru_page_replacement;

  localparam int MAX_FRAMES = lru_pr_pkg::MAX_FRAMES;
  localparam int FRAME_W    = lru_pr_pkg::FRAME_W;
  localparam int RANK_W     = lru_pr_pkg::RANK_W;
  localparam int PAGE_W     = lru_pr_pkg::PAGE_W;
  localparam int CFG_W      = lru_pr_pkg::CFG_W;
  localparam int OUT_DATA_W = lru_pr_pkg::OUT_DATA_W;
  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = lru_pr_pkg::FRAME_COUNT_RESET;

  localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
  localparam int TAIL_CYCLES = 40;     // settle time after the last result
  localparam int PHASE_ITEMS = 100;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [PAGE_W-1:0] page;
    logic              new_seq;
  } page_ref_t;

  typedef struct {
    logic                                  fault;
    logic [FRAME_W-1:0]                    frame_index;
    logic                                  replaced;
    logic [PAGE_W-1:0]                     replaced_page;
    logic [OUT_DATA_W-FRAME_W-PAGE_W-1:0]  pad;
  } page_result_t;

  // frame counts swept by the random phases; 0 and 17+ exercise clamping
  localparam logic [CFG_W-1:0] SWEEP [10] = '{
    CFG_W'(16), CFG_W'(1), CFG_W'(8), CFG_W'(17), CFG_W'(3),
    CFG_W'(0), CFG_W'(31), CFG_W'(5), CFG_W'(2), CFG_W'(12)
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [PAGE_W-1:0] s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // predictor state
  logic [CFG_W-1:0]  frame_count_reg = FRAME_COUNT_RESET;
  bit                held_valid [MAX_FRAMES];
  logic [PAGE_W-1:0] held_page  [MAX_FRAMES];
  logic [RANK_W-1:0] held_rank  [MAX_FRAMES];

  page_ref_t    request_q [$];   // requests waiting for the driver
  page_ref_t    active_ref;      // request currently on the bus
  page_result_t result_q [$];    // predicted results, oldest first
  page_result_t observed_q [$];  // results taken from the block, not yet checked
  idle_mode_t   idle_mode = IDLE_NONE;
  int           errors = 0;
  int           quiet_cycles = 0;

  lru_page_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),      // [7:0] page
    .s_tuser  (s_tuser),      // [0] new_sequence
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),      // [3:0] frame_index, [11:4] replaced_page, [15:12] zero
    .m_tuser  (m_tuser),      // [0] fault, [1] replaced
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)     // frame_count
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int valid_count();
    int c;
    c = 0;
    for (int i = 0; i < MAX_FRAMES; i++)
      if (held_valid[i]) c++;
    return c;
  endfunction

  // make frame f the most recent; frames ranked above it slide down by one
  function automatic void promote(int f);
    int top;
    logic [RANK_W-1:0] r;
    top = valid_count();
    r = held_rank[f];
    for (int i = 0; i < MAX_FRAMES; i++)
      if (held_valid[i] && i != f && held_rank[i] > r)
        held_rank[i] = held_rank[i] - 1'b1;
    held_rank[f] = RANK_W'(top - 1);
  endfunction

  function automatic page_result_t lru_lookup(page_ref_t req);
    page_result_t res;
    int n;
    int f;
    int i;
    bit found;
    res = '{default: '0};
    n = (frame_count_reg == 0) ? 1 :
        (frame_count_reg > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count_reg);
    if (req.new_seq) begin
      for (i = 0; i < MAX_FRAMES; i++) begin
        held_valid[i] = 1'b0;
        held_rank[i] = '0;
      end
    end
    // first frame, in index order, that holds the page or is empty
    f = 0;
    found = 1'b0;
    for (i = 0; i < n && !found; i++) begin
      if (!held_valid[i] || held_page[i] == req.page) begin
        f = i;
        found = 1'b1;
      end
    end
    if (found && held_valid[f]) begin
      promote(f);
    end else if (found) begin
      held_rank[f] = RANK_W'(valid_count());
      held_valid[f] = 1'b1;
      held_page[f] = req.page;
      res.fault = 1'b1;
    end else begin
      // all searched frames busy: evict the least recent, lowest index wins ties
      f = 0;
      for (i = 1; i < n; i++)
        if (held_rank[i] < held_rank[f]) f = i;
      res.replaced = 1'b1;
      res.replaced_page = held_page[f];
      held_page[f] = req.page;
      promote(f);
      res.fault = 1'b1;
    end
    res.frame_index = FRAME_W'(f);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Idle patterns
  // --------------------------------------------------------------------------
  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 75;
      IDLE_BOTH: return $urandom_range(99) < 17;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 75;
      IDLE_BOTH: return $urandom_range(99) < 17;
      default:   return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one request on the bus at a time, held until accepted.
  // The expected result is worked out at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    logic load;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        result_q.push_back(lru_lookup(active_ref));
      end
      if (!s_tvalid || s_tready) begin
        load = request_q.size() != 0 && !sender_waits();
        if (load) begin
          active_ref = request_q.pop_front();
          s_tdata <= active_ref.page;
          s_tuser <= active_ref.new_seq;
        end
        s_tvalid <= load;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: capture accepted results; backpressure per idle pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    page_result_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.fault         = m_tuser[0];
      seen.replaced      = m_tuser[1];
      seen.frame_index   = m_tdata[FRAME_W-1:0];
      seen.replaced_page = m_tdata[FRAME_W+PAGE_W-1:FRAME_W];
      seen.pad           = m_tdata[OUT_DATA_W-1:FRAME_W+PAGE_W];
      observed_q.push_back(seen);
    end
    m_tready <= !rst && !receiver_stalls();
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // compare on the falling edge so queue updates from the rising edge are settled;
  // at most one result per cycle, so one compare per cycle keeps up
  always @(negedge clk) begin : scoreboard
    page_result_t want;
    page_result_t got;
    if (observed_q.size() != 0) begin
      got = observed_q.pop_front();
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual frame %0h fault %0b",
                 $time, got.frame_index, got.fault);
        errors++;
      end else begin
        want = result_q.pop_front();
        check_field("fault", 16'(want.fault), 16'(got.fault));
        check_field("frame_index", 16'(want.frame_index), 16'(got.frame_index));
        check_field("replaced", 16'(want.replaced), 16'(got.replaced));
        check_field("replaced_page", 16'(want.replaced_page), 16'(got.replaced_page));
        check_field("tdata pad", 16'(want.pad), 16'(got.pad));
      end
    end
  end

  // watchdog: any handshake clears the count
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("lru_page_replacement verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_ref(int page, bit new_seq);
    page_ref_t r;
    r.page = PAGE_W'(page);
    r.new_seq = new_seq;
    request_q.push_back(r);
  endtask

  // sender holds off until the block is empty and every result is checked
  task automatic drain();
    do @(negedge clk);
    while (request_q.size() != 0 || s_tvalid || result_q.size() != 0 ||
           observed_q.size() != 0);
  endtask

  // only called with the block idle
  task automatic set_frame_count(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_count_reg = value;
    @(negedge clk);
  endtask

  // mostly references from a small working set so hits and evictions both occur
  task automatic random_refs(int count, int frames);
    int pool;
    int base;
    int roll;
    pool = frames + $urandom_range(4);
    base = $urandom_range(256 - pool);
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 3)
        push_ref($urandom_range(255), 1'b1);
      else if (roll < 85)
        push_ref(base + $urandom_range(pool - 1), 1'b0);
      else
        push_ref($urandom_range(255), 1'b0);
    end
  endtask

  initial begin : sequencer
    logic [CFG_W-1:0] count;
    int frames;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      held_valid[i] = 1'b0;
      held_page[i] = '0;
      held_rank[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset frame count of 4: fills incl. page 255, space and '*'
    idle_mode = IDLE_NONE;
    push_ref(0, 1'b1);
    push_ref(255, 1'b0);
    push_ref(32, 1'b0);
    push_ref(42, 1'b0);
    push_ref(0, 1'b0);     // hit
    push_ref(7, 1'b0);     // evicts least recent
    push_ref(32, 1'b0);    // hit
    push_ref(99, 1'b0);    // evict
    push_ref(99, 1'b0);    // hit on just-replaced frame
    push_ref(5, 1'b1);     // clear and refill
    push_ref(5, 1'b0);
    push_ref(255, 1'b0);
    push_ref(6, 1'b0);
    push_ref(8, 1'b0);
    drain();

    // lowered count: frames 2 and 3 stay resident but are out of the search
    set_frame_count(CFG_W'(2));
    push_ref(8, 1'b0);
    push_ref(6, 1'b0);
    push_ref(8, 1'b0);
    drain();

    // zero behaves as a single frame
    set_frame_count(CFG_W'(0));
    push_ref(1, 1'b0);
    push_ref(2, 1'b0);
    push_ref(2, 1'b0);
    drain();

    // above the maximum clamps to all frames; old frames 2, 3 come back in view
    set_frame_count(CFG_W'(31));
    push_ref(6, 1'b0);
    push_ref(9, 1'b0);
    drain();

    // random phases: one per swept frame count plus one at a random count, idle pattern rotating
    for (int p = 0; p <= $size(SWEEP); p++) begin
      count = (p < $size(SWEEP)) ? SWEEP[p] : CFG_W'($urandom_range(31));
      frames = (count == 0) ? 1 : (count > MAX_FRAMES) ? MAX_FRAMES : int'(count);
      set_frame_count(count);
      idle_mode = idle_mode_t'(p % 4);
      random_refs(PHASE_ITEMS, frames);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (result_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
    if (errors == 0 && result_q.size() == 0 && observed_q.size() == 0) begin
      $display("lru_page_replacement verification clean");
    end else begin
      $display("lru_page_replacement verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lru_pr_pkg.sv
rtl/core/lru_pr_ctrl.sv
rtl/core/lru_pr_datapath.sv
rtl/core/lru_page_replacement.sv
bench/tb_lru_page_replacement.sv
